### hdl/compressed_message_block_deframer_macros.svh
// Assertion macros used by the deframer core.
`ifndef COMPRESSED_MESSAGE_BLOCK_DEFRAMER_MACROS_SVH
`define COMPRESSED_MESSAGE_BLOCK_DEFRAMER_MACROS_SVH

`ifndef SYNTH
`define CMBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CMBD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define CMBD_ASSERT(lbl, prop, msg)
`define CMBD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### hdl/cmbd_pkg.sv
// Types and constants of the compressed message block deframer.
package cmbd_pkg;

	typedef enum logic [2:0] {
		PH_SOH,
		PH_LEN,
		PH_TITLE,
		PH_OFFSET,
		PH_MARK,
		PH_BLEN,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	localparam logic [2:0] EV_FRAME     = 3'd0;
	localparam logic [2:0] EV_TITLE     = 3'd1;
	localparam logic [2:0] EV_TITLE_END = 3'd2;
	localparam logic [2:0] EV_PAYLOAD   = 3'd3;
	localparam logic [2:0] EV_OK        = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;

	localparam logic [2:0] ERR_NONE        = 3'd0;
	localparam logic [2:0] ERR_NO_SOH      = 3'd1;
	localparam logic [2:0] ERR_TITLE_LONG  = 3'd2;
	localparam logic [2:0] ERR_OFFSET_NZ   = 3'd3;
	localparam logic [2:0] ERR_OFFSET_LONG = 3'd4;
	localparam logic [2:0] ERR_BAD_MARK    = 3'd5;
	localparam logic [2:0] ERR_CHECKSUM    = 3'd6;

	localparam logic [7:0] SOH_BYTE   = 8'h01;
	localparam logic [7:0] STX_BYTE   = 8'h02;
	localparam logic [7:0] EOT_BYTE   = 8'h04;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] OFFSET_MAX = 8'd6;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [7:0] data_byte;
		logic [2:0] error_code;
	} result_t;

endpackage

### hdl/cmbd_in_if.sv
// Input byte channel.
interface cmbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### hdl/cmbd_out_if.sv
// Result channel.
interface cmbd_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] data_byte;
	logic [2:0] error_code;

	modport source (output valid, output event_kind, output data_byte, output error_code,
		input ready);
	modport sink (input valid, input event_kind, input data_byte, input error_code,
		output ready);
endinterface

### hdl/cmbd_in_stage.sv
// Input register stage: holds one received byte until the core takes it.
module cmbd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	cmbd_in_if.sink    rx,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);
	assign rx.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end
endmodule

### hdl/cmbd_core.sv
// Deframing state machine: per-byte state update and result decode.
`include "compressed_message_block_deframer_macros.svh"

module cmbd_core #(
	parameter int TITLE_MAX = 179
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       rx_byte,
	output cmbd_pkg::result_t res
);
	import cmbd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] cnt_q, cnt_d;
	logic       ozero_q, ozero_d;
	logic [8:0] brem_q, brem_d;
	logic [7:0] sum_q, sum_d;
	logic       failed_q, failed_d;
	logic [8:0] brem_dec;
	logic [7:0] sum_add;

	assign brem_dec = brem_q - 9'd1;
	assign sum_add  = sum_q + rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SOH;
			cnt_q    <= '0;
			ozero_q  <= 1'b0;
			brem_q   <= '0;
			sum_q    <= '0;
			failed_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			ozero_q  <= ozero_d;
			brem_q   <= brem_d;
			sum_q    <= sum_d;
			failed_q <= failed_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		cnt_d          = cnt_q;
		ozero_d        = ozero_q;
		brem_d         = brem_q;
		sum_d          = sum_q;
		failed_d       = failed_q;
		res.event_kind = EV_FRAME;
		res.data_byte  = '0;
		res.error_code = ERR_NONE;
		if (!failed_q) begin
			unique case (phase_q)
				PH_LEN: begin
					phase_d = PH_TITLE;
					cnt_d   = '0;
				end
				PH_TITLE: begin
					if (rx_byte == 8'd0) begin
						res.event_kind = EV_TITLE_END;
						cnt_d          = '0;
						ozero_d        = 1'b0;
						phase_d        = PH_OFFSET;
					end else if (cnt_q >= 8'(TITLE_MAX)) begin
						res.error_code = ERR_TITLE_LONG;
					end else begin
						res.event_kind = EV_TITLE;
						res.data_byte  = rx_byte;
						cnt_d          = cnt_q + 8'd1;
					end
				end
				PH_OFFSET: begin
					if (rx_byte == 8'd0) begin
						sum_d = '0;
						if (ozero_q && cnt_q == 8'd1) begin
							cnt_d   = '0;
							phase_d = PH_MARK;
						end else begin
							res.error_code = ERR_OFFSET_NZ;
						end
					end else if (cnt_q >= OFFSET_MAX) begin
						res.error_code = ERR_OFFSET_LONG;
					end else begin
						ozero_d = (cnt_q == 8'd0) && (rx_byte == ZERO_CHAR);
						cnt_d   = cnt_q + 8'd1;
					end
				end
				PH_MARK: begin
					if (rx_byte == STX_BYTE) begin
						phase_d = PH_BLEN;
					end else if (rx_byte == EOT_BYTE) begin
						phase_d = PH_CHECK;
					end else begin
						res.error_code = ERR_BAD_MARK;
					end
				end
				PH_BLEN: begin
					// zero length means a full block of 256
					brem_d  = (rx_byte == 8'd0) ? 9'd256 : {1'b0, rx_byte};
					phase_d = PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					res.event_kind = EV_PAYLOAD;
					res.data_byte  = rx_byte;
					sum_d          = sum_add;
					brem_d         = brem_dec;
					if (brem_dec == 9'd0) begin
						phase_d = PH_MARK;
					end
				end
				PH_CHECK: begin
					if (sum_add != 8'd0) begin
						res.error_code = ERR_CHECKSUM;
					end else begin
						// rearm for the next message
						res.event_kind = EV_OK;
						phase_d        = PH_SOH;
						cnt_d          = '0;
						ozero_d        = 1'b0;
						brem_d         = '0;
						sum_d          = '0;
					end
				end
				default: begin
					if (rx_byte == SOH_BYTE) begin
						phase_d = PH_LEN;
					end else begin
						res.error_code = ERR_NO_SOH;
					end
				end
			endcase
			if (res.error_code != ERR_NONE) begin
				res.event_kind = EV_ERROR;
				res.data_byte  = '0;
				failed_d       = 1'b1;
			end
		end
	end

	`CMBD_ASSERT(a_failed_sticky, failed_q |=> failed_q, "failed state cleared without reset")
	`CMBD_ASSERT(a_error_sets_failed, (take && res.event_kind == EV_ERROR) |=> failed_q, "error did not set failed state")
	`CMBD_ASSERT_NEVER(a_kind_code_match, (res.event_kind == EV_ERROR) != (res.error_code != ERR_NONE), "error kind and code disagree")
	`CMBD_ASSERT_NEVER(a_payload_count, !failed_q && phase_q == PH_PAYLOAD && brem_q == 9'd0, "payload phase with empty block")
endmodule

### hdl/cmbd_out_stage.sv
// Result register: holds one result until the sink takes it.
module cmbd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cmbd_pkg::result_t res,
	output logic              free,
	cmbd_out_if.source        tx
);
	import cmbd_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free          = !valid_q || tx.ready;
	assign tx.valid      = valid_q;
	assign tx.event_kind = res_q.event_kind;
	assign tx.data_byte  = res_q.data_byte;
	assign tx.error_code = res_q.error_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule

### hdl/compressed_message_block_deframer.sv
// Path: input stage register, combinational core decode, then the result register.
// Throughput: one byte per cycle while the sink takes results; the core's state update sets the pace.
// While a result waits on the output, the core holds and the input stage keeps one byte.
// Reset (arst_n low) empties both stages and rearms to waiting for SOH, failed cleared.
// Title length limit is TITLE_MAX bytes.
module compressed_message_block_deframer #(
	parameter int TITLE_MAX = 179
) (
	input  logic       clk,
	input  logic       arst_n,
	cmbd_in_if.sink    rx,
	cmbd_out_if.source tx
);
	import cmbd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       take;
	result_t    res;

	assign take = valid_s1 && out_free;

	cmbd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	cmbd_core #(
		.TITLE_MAX (TITLE_MAX)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (byte_s1),
		.res     (res)
	);

	cmbd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.res    (res),
		.free   (out_free),
		.tx     (tx)
	);
endmodule
